// ===== rtl/assert_macros.svh =====
// assertion macros used by range_sum_segment_tree
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/rsst_pkg.sv =====
// shared types and constants of the range sum segment tree
// no dependencies; used by rsst_node_ram and range_sum_segment_tree
package rsst_pkg;

  // default parameter values
  localparam int MAX_SLOTS_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int IDX_W       = 10;  // slot and range bounds
  localparam int SIZE_W      = 11;  // size register and segment bounds
  localparam int SUM_W       = 42;  // node sums and result
  localparam int OUT_TDATA_W = 48;  // result padded to whole bytes

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_DOWN,
    ST_UPD_UP,
    ST_QRY_DOWN,
    ST_QRY_DRAIN,
    ST_FINISH
  } state_t;

  // node memory strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

// ===== rtl/rsst_node_ram.sv =====
// node sum memory: one write port, one read port, registered read data
// depends on rsst_pkg (ram_ctl_t, SUM_W, MAX_SLOTS_DEF)
module rsst_node_ram #(
  parameter int  DEPTH = 4 * rsst_pkg::MAX_SLOTS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  rsst_pkg::ram_ctl_t         ctl,
  input  logic [AW-1:0]              waddr,
  input  logic [rsst_pkg::SUM_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [rsst_pkg::SUM_W-1:0] rdata
);

  logic [rsst_pkg::SUM_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/range_sum_segment_tree.sv =====
// range sum segment tree: point update and inclusive range sum over the slots in use
// an item in range walks the tree from the root down to a leaf:
//   update writes the leaf, then one ancestor per step on the way up; no result
//   query: one or two prefix descents (second if range_low > 0), at most one read per level
// one item at a time; the single read port of the node memory sets the pace
// reset and every size write start a clearing pass over all 4*MAX_SLOTS nodes, no items taken
// depends on rsst_pkg, rsst_node_ram and assert_macros.svh
`include "assert_macros.svh"

module range_sum_segment_tree #(
  parameter int  MAX_SLOTS  = rsst_pkg::MAX_SLOTS_DEF,
  parameter int  VALUE_BITS = rsst_pkg::VALUE_BITS_DEF,
  localparam int IN_TDATA_W = ((3 * rsst_pkg::IDX_W + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: slot_index, new_value, range_low, range_high, zero pad
  input  logic [IN_TDATA_W-1:0]            s_axis_tdata,
  // tuser: opcode
  input  logic                             s_axis_tuser,
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: range_sum, zero pad
  output logic [rsst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // size_in_use write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsst_pkg::SIZE_W-1:0]      cfg_data
);

  localparam int NODE_COUNT = 4 * MAX_SLOTS;
  localparam int AW         = $clog2(NODE_COUNT);
  localparam int IW         = rsst_pkg::SIZE_W;
  localparam int XW         = rsst_pkg::IDX_W;
  localparam int SW         = rsst_pkg::SUM_W;
  localparam int SIZE_RST_I = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;
  localparam logic [IW-1:0] SIZE_RST = IW'(SIZE_RST_I);
  localparam logic [AW-1:0] CLR_LAST = AW'(NODE_COUNT - 1);
  localparam logic [AW-1:0] ROOT     = AW'(1);

  // control registers
  rsst_pkg::state_t state, state_next;
  logic [IW-1:0]    size;
  logic [AW-1:0]    clr_addr;
  logic             pend;
  logic             pend_neg;
  logic             out_valid;

  // payload registers
  logic [AW-1:0]    node;
  logic [IW-1:0]    seg_lo;
  logic [IW-1:0]    seg_hi;
  logic [IW-1:0]    target;
  logic [SW-1:0]    upd_sum;
  logic [SW-1:0]    acc;
  logic             phase;
  logic [IW-1:0]    q_lo;
  logic [SW-1:0]    out_data;

  // memory ports
  rsst_pkg::ram_ctl_t ram_ctl;
  logic [AW-1:0]      ram_waddr;
  logic [SW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [SW-1:0]      ram_rdata;

  // input field unpacking
  rsst_pkg::opcode_t in_op;
  logic [XW-1:0]         in_slot;
  logic [VALUE_BITS-1:0] in_value;
  logic [XW-1:0]         in_lo;
  logic [XW-1:0]         in_hi;
  logic [63:0]           val_wide;
  logic [SW-1:0]         val_sum;

  assign in_op    = rsst_pkg::opcode_t'(s_axis_tuser);
  assign in_slot  = s_axis_tdata[XW-1:0];
  assign in_value = s_axis_tdata[XW +: VALUE_BITS];
  assign in_lo    = s_axis_tdata[XW + VALUE_BITS +: XW];
  assign in_hi    = s_axis_tdata[2 * XW + VALUE_BITS +: XW];
  assign val_wide = {{(64 - VALUE_BITS){in_value[VALUE_BITS-1]}}, in_value};
  assign val_sum  = val_wide[SW-1:0];

  // handshakes
  logic in_fire, cfg_fire, out_free, finish_load;

  assign s_axis_tready = (state == rsst_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == rsst_pkg::ST_IDLE) || (state == rsst_pkg::ST_CLEAR);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign out_free      = !out_valid || m_axis_tready;
  assign finish_load   = (state == rsst_pkg::ST_FINISH) && out_free;

  // size write, saturated to the tree capacity
  logic [IW-1:0] size_wr;
  assign size_wr = (32'(cfg_data) > MAX_SLOTS) ? IW'(MAX_SLOTS) : cfg_data;

  // range checks on an arriving item
  logic [IW-1:0] size_last, in_slot_x, in_lo_x, in_hi_x, hi_clamp;
  logic          upd_ok, q_nonempty;

  assign size_last  = size - IW'(1);
  assign in_slot_x  = IW'(in_slot);
  assign in_lo_x    = IW'(in_lo);
  assign in_hi_x    = IW'(in_hi);
  assign hi_clamp   = (in_hi_x >= size) ? size_last : in_hi_x;
  assign upd_ok     = (size != '0) && (in_slot_x < size);
  assign q_nonempty = (size != '0) && (in_lo_x < size) && (in_lo_x <= hi_clamp);

  // descent step: split the current segment at its midpoint
  logic [IW-1:0] mid;
  logic          at_leaf, go_right, pass_again;
  logic [AW-1:0] node_left, node_right, node_par, node_sib, par_sib;

  assign mid        = seg_lo + ((seg_hi - seg_lo) >> 1);
  assign at_leaf    = (seg_lo == seg_hi);
  assign go_right   = (target > mid);
  assign pass_again = !phase && (q_lo != '0);
  assign node_left  = {node[AW-2:0], 1'b0};
  assign node_right = {node[AW-2:0], 1'b1};
  assign node_par   = {1'b0, node[AW-1:1]};
  assign node_sib   = node ^ ROOT;
  assign par_sib    = node_par ^ ROOT;

  // sums: ancestor on the way up, prefix accumulation on the way down
  logic [SW-1:0] up_sum, acc_next;

  assign up_sum = upd_sum + ram_rdata;

  always_comb begin
    acc_next = acc;
    if (pend) begin
      acc_next = pend_neg ? (acc - ram_rdata) : (acc + ram_rdata);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rsst_pkg::ST_CLEAR: begin
        if (cfg_fire) state_next = rsst_pkg::ST_CLEAR;
        else if (clr_addr == CLR_LAST) state_next = rsst_pkg::ST_IDLE;
      end
      rsst_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          state_next = rsst_pkg::ST_CLEAR;
        end else if (in_fire) begin
          if (in_op == rsst_pkg::OP_UPDATE) begin
            state_next = upd_ok ? rsst_pkg::ST_UPD_DOWN : rsst_pkg::ST_IDLE;
          end else begin
            state_next = q_nonempty ? rsst_pkg::ST_QRY_DOWN : rsst_pkg::ST_FINISH;
          end
        end
      end
      rsst_pkg::ST_UPD_DOWN: begin
        if (at_leaf) begin
          state_next = (node == ROOT) ? rsst_pkg::ST_IDLE : rsst_pkg::ST_UPD_UP;
        end
      end
      rsst_pkg::ST_UPD_UP: begin
        if (node_par == ROOT) state_next = rsst_pkg::ST_IDLE;
      end
      rsst_pkg::ST_QRY_DOWN: begin
        if (at_leaf && !pass_again) state_next = rsst_pkg::ST_QRY_DRAIN;
      end
      rsst_pkg::ST_QRY_DRAIN: state_next = rsst_pkg::ST_FINISH;
      rsst_pkg::ST_FINISH: begin
        if (out_free) state_next = rsst_pkg::ST_IDLE;
      end
      default: state_next = rsst_pkg::ST_CLEAR;
    endcase
  end

  // memory accesses per state
  // reads on the way up only touch siblings of the path, never the node written
  // in the same cycle, so no forwarding is needed
  always_comb begin
    ram_ctl   = '0;
    ram_waddr = node;
    ram_wdata = upd_sum;
    ram_raddr = node;
    unique case (state)
      rsst_pkg::ST_CLEAR: begin
        ram_ctl.wr_en = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
      end
      rsst_pkg::ST_UPD_DOWN: begin
        if (at_leaf) begin
          ram_ctl.wr_en = 1'b1;
          if (node != ROOT) begin
            ram_ctl.rd_en = 1'b1;
            ram_raddr     = node_sib;
          end
        end
      end
      rsst_pkg::ST_UPD_UP: begin
        ram_ctl.wr_en = 1'b1;
        ram_waddr     = node_par;
        ram_wdata     = up_sum;
        if (node_par != ROOT) begin
          ram_ctl.rd_en = 1'b1;
          ram_raddr     = par_sib;
        end
      end
      rsst_pkg::ST_QRY_DOWN: begin
        // leaf itself, or the left child passed over when turning right
        if (at_leaf) begin
          ram_ctl.rd_en = 1'b1;
        end else if (go_right) begin
          ram_ctl.rd_en = 1'b1;
          ram_raddr     = node_left;
        end
      end
      default: begin
      end
    endcase
  end

  rsst_node_ram #(
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsst_pkg::ST_CLEAR;
      size      <= SIZE_RST;
      clr_addr  <= '0;
      pend      <= 1'b0;
      pend_neg  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        size     <= size_wr;
        clr_addr <= '0;
      end else if (state == rsst_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      pend     <= ram_ctl.rd_en && (state == rsst_pkg::ST_QRY_DOWN);
      pend_neg <= phase;
      if (finish_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    acc <= in_fire ? '0 : acc_next;
    unique case (state)
      rsst_pkg::ST_IDLE: begin
        if (in_fire) begin
          node    <= ROOT;
          seg_lo  <= '0;
          seg_hi  <= size_last;
          upd_sum <= val_sum;
          phase   <= 1'b0;
          q_lo    <= in_lo_x;
          target  <= (in_op == rsst_pkg::OP_UPDATE) ? in_slot_x : hi_clamp;
        end
      end
      rsst_pkg::ST_UPD_DOWN, rsst_pkg::ST_QRY_DOWN: begin
        if (!at_leaf) begin
          if (go_right) begin
            node   <= node_right;
            seg_lo <= mid + IW'(1);
          end else begin
            node   <= node_left;
            seg_hi <= mid;
          end
        end else if (state == rsst_pkg::ST_QRY_DOWN && pass_again) begin
          // second prefix, subtracted: slots below range_low
          node   <= ROOT;
          seg_lo <= '0;
          seg_hi <= size_last;
          target <= q_lo - IW'(1);
          phase  <= 1'b1;
        end
      end
      rsst_pkg::ST_UPD_UP: begin
        node    <= node_par;
        upd_sum <= up_sum;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish_load) out_data <= acc;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(rsst_pkg::OUT_TDATA_W - SW){1'b0}}, out_data};

  // checks
  `ASSERT_CLK(a_no_rw_same_node, ram_ctl.wr_en && ram_ctl.rd_en |-> ram_waddr != ram_raddr, "node read and written in one cycle")
  `ASSERT_CLK(a_cfg_clears, cfg_fire |=> state == rsst_pkg::ST_CLEAR, "size write did not start clearing")
  `ASSERT_NEVER(a_read_in_range, ram_ctl.rd_en && (32'(ram_raddr) >= NODE_COUNT), "node read beyond tree")

endmodule
